// ===== rtl/rssi_proximity_zone_tracker_unit_defines.svh =====
// Assertion macros shared by the RSSI proximity zone tracker RTL.
`ifndef RSSI_PROXIMITY_ZONE_TRACKER_UNIT_DEFINES_SVH
`define RSSI_PROXIMITY_ZONE_TRACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define RPZT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define RPZT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPZT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define RPZT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/rpzt_pkg.sv =====
// Package with widths, codes, reset values and shared types of the zone tracker.
`default_nettype none

package rpzt_pkg;

  // Window geometry.
  localparam int WINDOW_DEPTH = 5;
  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);

  // Field widths.
  localparam int RSSI_W     = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int ELAPSED_W  = 17;
  localparam int ZONE_W     = 3;
  localparam int BARS_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Window sum, and the shared add/subtract unit one bit wider.
  localparam int SUM_W  = RSSI_W + SLOT_W;
  localparam int ALU_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_FAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_TEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_SEVEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_FIVE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_THREE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT = 3'd7;

  // Register reset values.
  localparam logic [RSSI_W-1:0]    ZONE_NEAR_RESET    = 8'hC9; // -55
  localparam logic [RSSI_W-1:0]    ZONE_MEDIUM_RESET  = 8'hBA; // -70
  localparam logic [RSSI_W-1:0]    ZONE_FAR_RESET     = 8'hAB; // -85
  localparam logic [RSSI_W-1:0]    BAR_TEN_RESET      = 8'hC9; // -55
  localparam logic [RSSI_W-1:0]    BAR_SEVEN_RESET    = 8'hBF; // -65
  localparam logic [RSSI_W-1:0]    BAR_FIVE_RESET     = 8'hB5; // -75
  localparam logic [RSSI_W-1:0]    BAR_THREE_RESET    = 8'hAB; // -85
  localparam logic [TIMEOUT_W-1:0] LOST_TIMEOUT_RESET = 16'd5000;
  localparam logic [RSSI_W-1:0]    HELD_AVERAGE_RESET = 8'h81; // -127

  // Item and report kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic REPORT_SAMPLE = 1'b0;
  localparam logic REPORT_LOST   = 1'b1;

  // Zone codes.
  localparam logic [ZONE_W-1:0] ZONE_NONE   = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_NEAR   = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_MEDIUM = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_FAR    = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_LOST   = 3'd4;

  // Bar levels.
  localparam logic [BARS_W-1:0] BARS_ZERO  = 4'd0;
  localparam logic [BARS_W-1:0] BARS_THREE = 4'd3;
  localparam logic [BARS_W-1:0] BARS_FIVE  = 4'd5;
  localparam logic [BARS_W-1:0] BARS_SEVEN = 4'd7;
  localparam logic [BARS_W-1:0] BARS_TEN   = 4'd10;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // Threshold levels used by the classifier, each a signed byte.
  typedef struct packed {
    logic [RSSI_W-1:0] zone_near;
    logic [RSSI_W-1:0] zone_medium;
    logic [RSSI_W-1:0] zone_far;
    logic [RSSI_W-1:0] bar_ten;
    logic [RSSI_W-1:0] bar_seven;
    logic [RSSI_W-1:0] bar_five;
    logic [RSSI_W-1:0] bar_three;
  } levels_t;

endpackage

`default_nettype wire

// ===== rtl/rpzt_alu.sv =====
// Shared add/subtract unit used for summing, division steps and negation.
`default_nettype none

module rpzt_alu (
  input  rpzt_pkg::alu_req_t           req,
  output logic [rpzt_pkg::ALU_W-1:0]   result
);

  // Two's complement add or subtract; the sequencer picks the operands.
  always_comb begin
    if (req.sub) begin
      result = req.a - req.b;
    end else begin
      result = req.a + req.b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpzt_classify.sv =====
// Zone and bar classification of a signed window average.
`default_nettype none

module rpzt_classify (
  input  logic [rpzt_pkg::RSSI_W-1:0] avg,
  input  rpzt_pkg::levels_t           levels,
  output logic [rpzt_pkg::ZONE_W-1:0] zone,
  output logic [rpzt_pkg::BARS_W-1:0] bars
);

  // Zone: the first level that the average reaches decides.
  always_comb begin
    if ($signed(avg) >= $signed(levels.zone_near)) begin
      zone = rpzt_pkg::ZONE_NEAR;
    end else if ($signed(avg) >= $signed(levels.zone_medium)) begin
      zone = rpzt_pkg::ZONE_MEDIUM;
    end else if ($signed(avg) >= $signed(levels.zone_far)) begin
      zone = rpzt_pkg::ZONE_FAR;
    end else begin
      zone = rpzt_pkg::ZONE_LOST;
    end
  end

  // Bars: tested from ten downwards in the same way.
  always_comb begin
    if ($signed(avg) >= $signed(levels.bar_ten)) begin
      bars = rpzt_pkg::BARS_TEN;
    end else if ($signed(avg) >= $signed(levels.bar_seven)) begin
      bars = rpzt_pkg::BARS_SEVEN;
    end else if ($signed(avg) >= $signed(levels.bar_five)) begin
      bars = rpzt_pkg::BARS_FIVE;
    end else if ($signed(avg) >= $signed(levels.bar_three)) begin
      bars = rpzt_pkg::BARS_THREE;
    end else begin
      bars = rpzt_pkg::BARS_ZERO;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rssi_proximity_zone_tracker_unit.sv =====
// Top level of the RSSI proximity zone tracker: sequencer, window and registers.
//
// Usage. Words enter on the input channel (in_valid, in_stall, kind, rssi) and
// reports leave on the output channel (out_valid, out_stall and the report
// fields). A word moves at a rising edge where valid is high and stall is low.
// A sample word is written into a five-entry ring window; the filled entries
// are then summed one per cycle through a single add/subtract unit, and the
// same unit runs a restoring divide, one quotient bit per cycle, followed by a
// sign fix. S_FINISH registers the report once out_stall no longer holds the
// last one. The sum runs over count entries, the number filled (one to five);
// no further word is taken until the sequencer is idle again. A tick word
// leaves the sequencer idle; one that passes the timeout gives a lost report
// on the next cycle. Synchronous reset clears the control state, restores the
// register reset values and empties the window; the window contents themselves
// are not cleared. While out_stall holds a report, the block keeps it steady and
// takes no further word until it has gone. Registers are written through
// cfg_we, cfg_index and cfg_data while idle. The block does not enforce this.
`default_nettype none
`include "rssi_proximity_zone_tracker_unit_defines.svh"

module rssi_proximity_zone_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [rpzt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpzt_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [rpzt_pkg::RSSI_W-1:0]          rssi,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 report_kind,
  output logic [rpzt_pkg::RSSI_W-1:0]          mean_rssi,
  output logic [rpzt_pkg::ZONE_W-1:0]          zone,
  output logic [rpzt_pkg::ZONE_W-1:0]          prior_zone,
  output logic                                 zone_changed,
  output logic [rpzt_pkg::BARS_W-1:0]          bars
);

  localparam int SLOT_W  = rpzt_pkg::SLOT_W;
  localparam int COUNT_W = rpzt_pkg::COUNT_W;
  localparam int SUM_W   = rpzt_pkg::SUM_W;
  localparam int ALU_W   = rpzt_pkg::ALU_W;
  localparam int STEP_W  = rpzt_pkg::STEP_W;
  localparam int RSSI_W  = rpzt_pkg::RSSI_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SUM    = 6'b000010,
    S_ABS    = 6'b000100,
    S_DIV    = 6'b001000,
    S_SIGN   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  rpzt_pkg::levels_t                levels;
  logic [rpzt_pkg::TIMEOUT_W-1:0]   lost_timeout;

  // Tracking state.
  logic [RSSI_W-1:0]                window [rpzt_pkg::WINDOW_DEPTH];
  logic [SLOT_W-1:0]                write_slot;
  logic                             window_filled;
  logic [RSSI_W-1:0]                held_average;
  logic [rpzt_pkg::ZONE_W-1:0]      current_zone;
  logic [rpzt_pkg::ELAPSED_W-1:0]   elapsed;

  // Working registers of the sequencer.
  logic [COUNT_W-1:0]               count;
  logic [COUNT_W-1:0]               idx;
  logic [SUM_W-1:0]                 acc;
  logic [SUM_W-1:0]                 dvd;
  logic [COUNT_W-1:0]               rem;
  logic                             neg;
  logic [STEP_W-1:0]                step;

  // Combinational helpers.
  rpzt_pkg::alu_req_t               alu_req;
  logic [ALU_W-1:0]                 alu_result;
  logic [COUNT_W:0]                 shifted;
  logic                             trial_ok;
  logic [COUNT_W-1:0]               idx_next;
  logic                             in_take;
  logic                             out_take;
  logic                             slot_last;
  logic [COUNT_W-1:0]               count_next;
  logic [rpzt_pkg::ELAPSED_W-1:0]   elapsed_next;
  logic                             timeout_hit;
  logic [rpzt_pkg::ZONE_W-1:0]      class_zone;
  logic [rpzt_pkg::BARS_W-1:0]      class_bars;

  // Handshake.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Window slot and fill count for the sample being taken.
  assign slot_last  = (write_slot == SLOT_W'(rpzt_pkg::WINDOW_DEPTH - 1));
  assign count_next = (window_filled || slot_last) ?
                      COUNT_W'(rpzt_pkg::WINDOW_DEPTH) :
                      COUNT_W'(COUNT_W'(write_slot) + 1'b1);

  // Tick counter and timeout test.
  assign elapsed_next = rpzt_pkg::ELAPSED_W'(elapsed + 1'b1);
  assign timeout_hit  = elapsed_next > {1'b0, lost_timeout};

  // Division step operands.
  assign shifted  = {rem, dvd[SUM_W-1]};
  assign trial_ok = !alu_result[ALU_W-1];
  assign idx_next = COUNT_W'(idx + 1'b1);

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      S_SUM: begin
        alu_req.sub = 1'b0;
        alu_req.a   = {acc[SUM_W-1], acc};
        alu_req.b   = {{(ALU_W - RSSI_W){window[idx[SLOT_W-1:0]][RSSI_W-1]}},
                       window[idx[SLOT_W-1:0]]};
      end
      S_ABS: begin
        alu_req.b = {acc[SUM_W-1], acc};
      end
      S_DIV: begin
        alu_req.a = {{(ALU_W - COUNT_W - 1){1'b0}}, shifted};
        alu_req.b = {{(ALU_W - COUNT_W){1'b0}}, count};
      end
      S_SIGN: begin
        alu_req.b = {1'b0, dvd};
      end
      default: begin
        alu_req.sub = 1'b1;
      end
    endcase
  end

  rpzt_alu u_alu (
    .req    (alu_req),
    .result (alu_result)
  );

  rpzt_classify u_classify (
    .avg    (held_average),
    .levels (levels),
    .zone   (class_zone),
    .bars   (class_bars)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      levels.zone_near   <= rpzt_pkg::ZONE_NEAR_RESET;
      levels.zone_medium <= rpzt_pkg::ZONE_MEDIUM_RESET;
      levels.zone_far    <= rpzt_pkg::ZONE_FAR_RESET;
      levels.bar_ten     <= rpzt_pkg::BAR_TEN_RESET;
      levels.bar_seven   <= rpzt_pkg::BAR_SEVEN_RESET;
      levels.bar_five    <= rpzt_pkg::BAR_FIVE_RESET;
      levels.bar_three   <= rpzt_pkg::BAR_THREE_RESET;
      lost_timeout       <= rpzt_pkg::LOST_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpzt_pkg::REG_ZONE_NEAR:    levels.zone_near   <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_ZONE_MEDIUM:  levels.zone_medium <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_ZONE_FAR:     levels.zone_far    <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_BAR_TEN:      levels.bar_ten     <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_BAR_SEVEN:    levels.bar_seven   <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_BAR_FIVE:     levels.bar_five    <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_BAR_THREE:    levels.bar_three   <= cfg_data[RSSI_W-1:0];
        rpzt_pkg::REG_LOST_TIMEOUT: lost_timeout       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Window storage: written once per sample, no reset.
  always_ff @(posedge clk) begin
    if (in_take && (kind == rpzt_pkg::KIND_SAMPLE)) begin
      window[write_slot] <= rssi;
    end
  end

  // Sequencer and tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_slot    <= '0;
      window_filled <= 1'b0;
      held_average  <= rpzt_pkg::HELD_AVERAGE_RESET;
      current_zone  <= rpzt_pkg::ZONE_NONE;
      elapsed       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (kind == rpzt_pkg::KIND_SAMPLE) begin
              write_slot    <= slot_last ? '0 : SLOT_W'(write_slot + 1'b1);
              window_filled <= window_filled || slot_last;
              count         <= count_next;
              idx           <= '0;
              acc           <= '0;
              elapsed       <= '0;
              state         <= S_SUM;
            end else if (timeout_hit) begin
              elapsed      <= '0;
              current_zone <= rpzt_pkg::ZONE_LOST;
            end else begin
              elapsed <= elapsed_next;
            end
          end
        end
        // One window entry added per cycle.
        S_SUM: begin
          acc <= alu_result[SUM_W-1:0];
          idx <= idx_next;
          if (idx_next == count) begin
            state <= S_ABS;
          end
        end
        // Divide the magnitude; the sign is restored afterwards.
        S_ABS: begin
          neg   <= acc[SUM_W-1];
          dvd   <= acc[SUM_W-1] ? alu_result[SUM_W-1:0] : acc;
          rem   <= '0;
          step  <= STEP_W'(SUM_W);
          state <= S_DIV;
        end
        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          rem  <= trial_ok ? alu_result[COUNT_W-1:0] : shifted[COUNT_W-1:0];
          dvd  <= {dvd[SUM_W-2:0], trial_ok};
          step <= STEP_W'(step - 1'b1);
          if (step == STEP_W'(1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          held_average <= neg ? alu_result[RSSI_W-1:0] : dvd[RSSI_W-1:0];
          state        <= S_FINISH;
        end
        // Wait for the output register to be free, then report.
        S_FINISH: begin
          if (!(out_valid && out_stall)) begin
            current_zone <= class_zone;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      if ((state == S_FINISH) && !(out_valid && out_stall)) begin
        out_valid    <= 1'b1;
        report_kind  <= rpzt_pkg::REPORT_SAMPLE;
        mean_rssi    <= held_average;
        zone         <= class_zone;
        prior_zone   <= current_zone;
        zone_changed <= (class_zone != current_zone);
        bars         <= class_bars;
      end else if (in_take && (kind == rpzt_pkg::KIND_TICK) && timeout_hit) begin
        out_valid    <= 1'b1;
        report_kind  <= rpzt_pkg::REPORT_LOST;
        mean_rssi    <= held_average;
        zone         <= rpzt_pkg::ZONE_LOST;
        prior_zone   <= current_zone;
        zone_changed <= (current_zone != rpzt_pkg::ZONE_LOST);
        bars         <= rpzt_pkg::BARS_ZERO;
      end
    end
  end

  // Checks on the sequencer and the reports.
  `RPZT_ASSERT_IMPLIES(a_rem_below_divisor, clk, rst, state == S_DIV, rem < count, "remainder not below divisor")
  `RPZT_ASSERT_NEXT(a_sample_starts_sum, clk, rst, in_take && (kind == rpzt_pkg::KIND_SAMPLE), state == S_SUM, "sample did not start summing")
  `RPZT_ASSERT_IMPLIES(a_lost_report_shape, clk, rst, out_valid && (report_kind == rpzt_pkg::REPORT_LOST), (zone == rpzt_pkg::ZONE_LOST) && (bars == rpzt_pkg::BARS_ZERO), "lost report malformed")
  `RPZT_ASSERT_IMPLIES(a_sample_clears_ticks, clk, rst, out_valid && (report_kind == rpzt_pkg::REPORT_SAMPLE), elapsed == '0, "tick count not cleared by sample")

endmodule

`default_nettype wire

// ===== verif/rpzt_report_checker.sv =====
`timescale 1ns / 100ps
// Report checker for the zone tracker: models the block from accepted words.
module rpzt_report_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rpzt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpzt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            kind,
  input  logic [rpzt_pkg::RSSI_W-1:0]     rssi,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            report_kind,
  input  logic [rpzt_pkg::RSSI_W-1:0]     mean_rssi,
  input  logic [rpzt_pkg::ZONE_W-1:0]     zone,
  input  logic [rpzt_pkg::ZONE_W-1:0]     prior_zone,
  input  logic                            zone_changed,
  input  logic [rpzt_pkg::BARS_W-1:0]     bars,
  output int                              fail_count,
  output int                              pending,
  output int                              reports_seen,
  output int                              lost_seen
);

  typedef struct packed {
    logic                        report_kind;
    logic [rpzt_pkg::RSSI_W-1:0] avg;
    logic [rpzt_pkg::ZONE_W-1:0] zone;
    logic [rpzt_pkg::ZONE_W-1:0] prior;
    logic                        changed;
    logic [rpzt_pkg::BARS_W-1:0] bars;
  } zone_report_t;

  // Local copy of the threshold registers.
  logic signed [rpzt_pkg::RSSI_W-1:0] near_lvl, medium_lvl, far_lvl;
  logic signed [rpzt_pkg::RSSI_W-1:0] ten_lvl, seven_lvl, five_lvl, three_lvl;
  logic [rpzt_pkg::TIMEOUT_W-1:0]     timeout_lvl;

  // Local copy of the tracking state.
  logic signed [rpzt_pkg::RSSI_W-1:0] window [rpzt_pkg::WINDOW_DEPTH];
  int                                 slot;
  bit                                 filled;
  logic signed [rpzt_pkg::RSSI_W-1:0] held_avg;
  logic [rpzt_pkg::ZONE_W-1:0]        cur_zone;
  logic [rpzt_pkg::ELAPSED_W-1:0]     elapsed;

  zone_report_t awaited_reports[$];
  int fails = 0;
  int seen = 0;
  int lost = 0;

  function automatic logic [rpzt_pkg::ZONE_W-1:0] zone_of(
    input logic signed [rpzt_pkg::RSSI_W-1:0] a
  );
    if (a >= near_lvl) return rpzt_pkg::ZONE_NEAR;
    if (a >= medium_lvl) return rpzt_pkg::ZONE_MEDIUM;
    if (a >= far_lvl) return rpzt_pkg::ZONE_FAR;
    return rpzt_pkg::ZONE_LOST;
  endfunction

  function automatic logic [rpzt_pkg::BARS_W-1:0] bars_of(
    input logic signed [rpzt_pkg::RSSI_W-1:0] a
  );
    if (a >= ten_lvl) return rpzt_pkg::BARS_TEN;
    if (a >= seven_lvl) return rpzt_pkg::BARS_SEVEN;
    if (a >= five_lvl) return rpzt_pkg::BARS_FIVE;
    if (a >= three_lvl) return rpzt_pkg::BARS_THREE;
    return rpzt_pkg::BARS_ZERO;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // A sample goes into the ring, then the filled entries are averaged and classified.
  task automatic take_sample(input logic signed [rpzt_pkg::RSSI_W-1:0] value);
    int           sum;
    int           count;
    zone_report_t r;
    r.prior = cur_zone;
    window[slot] = value;
    slot++;
    if (slot >= rpzt_pkg::WINDOW_DEPTH) begin
      slot = 0;
      filled = 1'b1;
    end
    count = filled ? rpzt_pkg::WINDOW_DEPTH : slot;
    sum = 0;
    for (int i = 0; i < count; i++) sum += window[i];
    // Integer division truncates toward zero, as the block does.
    held_avg = rpzt_pkg::RSSI_W'(sum / count);
    elapsed = '0;
    cur_zone = zone_of(held_avg);
    r.report_kind = rpzt_pkg::REPORT_SAMPLE;
    r.avg = held_avg;
    r.zone = cur_zone;
    r.changed = (cur_zone != r.prior);
    r.bars = bars_of(held_avg);
    awaited_reports.push_back(r);
  endtask

  // A tick only reports when the elapsed count passes the timeout.
  task automatic take_tick();
    zone_report_t r;
    elapsed = elapsed + 1'b1;
    if (elapsed > timeout_lvl) begin
      r.prior = cur_zone;
      cur_zone = rpzt_pkg::ZONE_LOST;
      elapsed = '0;
      r.report_kind = rpzt_pkg::REPORT_LOST;
      r.avg = held_avg;
      r.zone = rpzt_pkg::ZONE_LOST;
      r.changed = (r.prior != rpzt_pkg::ZONE_LOST);
      r.bars = rpzt_pkg::BARS_ZERO;
      awaited_reports.push_back(r);
    end
  endtask

  // Reports are checked before the word of the same edge is modelled.
  always @(posedge clk) begin
    zone_report_t want;
    if (rst) begin
      near_lvl = rpzt_pkg::ZONE_NEAR_RESET;
      medium_lvl = rpzt_pkg::ZONE_MEDIUM_RESET;
      far_lvl = rpzt_pkg::ZONE_FAR_RESET;
      ten_lvl = rpzt_pkg::BAR_TEN_RESET;
      seven_lvl = rpzt_pkg::BAR_SEVEN_RESET;
      five_lvl = rpzt_pkg::BAR_FIVE_RESET;
      three_lvl = rpzt_pkg::BAR_THREE_RESET;
      timeout_lvl = rpzt_pkg::LOST_TIMEOUT_RESET;
      slot = 0;
      filled = 1'b0;
      held_avg = rpzt_pkg::HELD_AVERAGE_RESET;
      cur_zone = rpzt_pkg::ZONE_NONE;
      elapsed = '0;
      awaited_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (report_kind == rpzt_pkg::REPORT_LOST) lost++;
        if (awaited_reports.size() == 0) begin
          fails++;
          $display("%0t: report with nothing awaited, expected none, actual kind %0d mean %0d",
                   $time, report_kind, $signed(mean_rssi));
        end else begin
          want = awaited_reports.pop_front();
          check_field("report_kind", want.report_kind, report_kind);
          check_field("mean_rssi", $signed(want.avg), $signed(mean_rssi));
          check_field("zone", want.zone, zone);
          check_field("prior_zone", want.prior, prior_zone);
          check_field("zone_changed", want.changed, zone_changed);
          check_field("bars", want.bars, bars);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          rpzt_pkg::REG_ZONE_NEAR:    near_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_ZONE_MEDIUM:  medium_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_ZONE_FAR:     far_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_BAR_TEN:      ten_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_BAR_SEVEN:    seven_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_BAR_FIVE:     five_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_BAR_THREE:    three_lvl = cfg_data[rpzt_pkg::RSSI_W-1:0];
          rpzt_pkg::REG_LOST_TIMEOUT: timeout_lvl = cfg_data[rpzt_pkg::TIMEOUT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (kind == rpzt_pkg::KIND_SAMPLE) take_sample($signed(rssi));
        else take_tick();
      end
    end
    fail_count <= fails;
    pending <= awaited_reports.size();
    reports_seen <= seen;
    lost_seen <= lost;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the zone tracker: clock, reset, words, register settings and verdict.
module tb_top;

  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int SETTLE_CYCLES    = 30;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WORDS_PER_PHASE  = 155;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [rpzt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rpzt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            kind;
  logic [rpzt_pkg::RSSI_W-1:0]     rssi;
  logic                            out_valid;
  logic                            out_stall;
  logic                            report_kind;
  logic [rpzt_pkg::RSSI_W-1:0]     mean_rssi;
  logic [rpzt_pkg::ZONE_W-1:0]     zone;
  logic [rpzt_pkg::ZONE_W-1:0]     prior_zone;
  logic                            zone_changed;
  logic [rpzt_pkg::BARS_W-1:0]     bars;

  int fail_count;
  int pending;
  int reports_seen;
  int lost_seen;

  // Sender state and run statistics.
  bit                             offering;
  bit                             gaps_on;
  bit                             long_hold_req;
  int                             burst_left;
  int                             phase_words;
  int                             samples_sent;
  int                             ticks_sent;
  int                             settings_used;
  int                             cycles;
  rpzt_pkg::levels_t              set_levels;
  logic [rpzt_pkg::TIMEOUT_W-1:0] set_timeout;

  rssi_proximity_zone_tracker_unit dut (.*);

  rpzt_report_checker report_check (.*);

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d reports outstanding.", pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall density changes from stretch to stretch, with one long hold on request.
  initial begin
    int stall_pct;
    int mode_left;
    int held;
    stall_pct = 0;
    mode_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        held = 0;
        while (held < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one word and hold it until taken; a burst may end in a random idle gap.
  task automatic offer(input logic word_kind, input logic [rpzt_pkg::RSSI_W-1:0] word_rssi);
    int gap;
    if (!offering) in_valid <= 1'b1;
    offering = 1'b1;
    kind <= word_kind;
    rssi <= word_rssi;
    do @(posedge clk); while (in_stall);
    if (word_kind == rpzt_pkg::KIND_SAMPLE) samples_sent++;
    else ticks_sent++;
    phase_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
      if (gaps_on && gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every awaited report has left the block.
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rpzt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpzt_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Write every register from the current setting; upper data bits of the levels are junk.
  task automatic apply_settings();
    write_reg(rpzt_pkg::REG_ZONE_NEAR, {rpzt_pkg::RSSI_W'($urandom), set_levels.zone_near});
    write_reg(rpzt_pkg::REG_ZONE_MEDIUM,
              {rpzt_pkg::RSSI_W'($urandom), set_levels.zone_medium});
    write_reg(rpzt_pkg::REG_ZONE_FAR, {rpzt_pkg::RSSI_W'($urandom), set_levels.zone_far});
    write_reg(rpzt_pkg::REG_BAR_TEN, {rpzt_pkg::RSSI_W'($urandom), set_levels.bar_ten});
    write_reg(rpzt_pkg::REG_BAR_SEVEN, {rpzt_pkg::RSSI_W'($urandom), set_levels.bar_seven});
    write_reg(rpzt_pkg::REG_BAR_FIVE, {rpzt_pkg::RSSI_W'($urandom), set_levels.bar_five});
    write_reg(rpzt_pkg::REG_BAR_THREE, {rpzt_pkg::RSSI_W'($urandom), set_levels.bar_three});
    write_reg(rpzt_pkg::REG_LOST_TIMEOUT, set_timeout);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [rpzt_pkg::RSSI_W-1:0] clamp8(input int v);
    if (v > 127) return rpzt_pkg::RSSI_W'(127);
    if (v < -128) return rpzt_pkg::RSSI_W'(-128);
    return rpzt_pkg::RSSI_W'(v);
  endfunction

  // Thresholds that fall in the usual order, each 0 to 20 dB below the last.
  task automatic pick_ordered_levels();
    int v;
    v = int'($urandom_range(255)) - 128;
    set_levels.zone_near = clamp8(v);
    v -= int'($urandom_range(20));
    set_levels.zone_medium = clamp8(v);
    v -= int'($urandom_range(20));
    set_levels.zone_far = clamp8(v);
    v = int'($urandom_range(255)) - 128;
    set_levels.bar_ten = clamp8(v);
    v -= int'($urandom_range(20));
    set_levels.bar_seven = clamp8(v);
    v -= int'($urandom_range(20));
    set_levels.bar_five = clamp8(v);
    v -= int'($urandom_range(20));
    set_levels.bar_three = clamp8(v);
  endtask

  // Either any byte, or a value close to one of the current thresholds.
  function automatic logic [rpzt_pkg::RSSI_W-1:0] pick_rssi();
    logic [rpzt_pkg::RSSI_W-1:0] lvl;
    int                          off;
    if ($urandom_range(1) == 0) return rpzt_pkg::RSSI_W'($urandom);
    lvl = set_levels[rpzt_pkg::RSSI_W*$urandom_range(6) +: rpzt_pkg::RSSI_W];
    off = $urandom_range(12);
    return clamp8(int'($signed(lvl)) + off - 6);
  endfunction

  // Mostly runs of samples followed by tick runs around the timeout, plus odd words.
  task automatic run_phase();
    int n;
    int tick_run;
    int tick_cap;
    phase_words = 0;
    tick_cap = (set_timeout < 40) ? int'(set_timeout) + 2 : 40;
    while (phase_words < WORDS_PER_PHASE) begin
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(1, 6);
        repeat (n) offer(rpzt_pkg::KIND_SAMPLE, pick_rssi());
        tick_run = $urandom_range(0, tick_cap);
        repeat (tick_run) offer(rpzt_pkg::KIND_TICK, rpzt_pkg::RSSI_W'($urandom));
      end else begin
        offer(($urandom_range(1) == 0) ? rpzt_pkg::KIND_SAMPLE : rpzt_pkg::KIND_TICK,
              rpzt_pkg::RSSI_W'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= rpzt_pkg::REG_ZONE_NEAR;
    cfg_data <= '0;
    in_valid <= 1'b0;
    kind <= rpzt_pkg::KIND_SAMPLE;
    rssi <= '0;
    offering = 1'b0;
    gaps_on = 1'b1;
    long_hold_req = 1'b0;
    burst_left = 0;
    samples_sent = 0;
    ticks_sent = 0;
    settings_used = 0;
    cycles = 0;
    set_levels = {rpzt_pkg::ZONE_NEAR_RESET, rpzt_pkg::ZONE_MEDIUM_RESET,
                  rpzt_pkg::ZONE_FAR_RESET, rpzt_pkg::BAR_TEN_RESET,
                  rpzt_pkg::BAR_SEVEN_RESET, rpzt_pkg::BAR_FIVE_RESET,
                  rpzt_pkg::BAR_THREE_RESET};
    set_timeout = rpzt_pkg::LOST_TIMEOUT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset levels: partial window, extremes, truncation of a negative sum, exact threshold.
    offer(rpzt_pkg::KIND_SAMPLE, 8'h80);
    offer(rpzt_pkg::KIND_SAMPLE, 8'h7F);
    offer(rpzt_pkg::KIND_SAMPLE, 8'h00);
    offer(rpzt_pkg::KIND_SAMPLE, 8'hFF);
    offer(rpzt_pkg::KIND_SAMPLE, 8'hFE);
    repeat (5) offer(rpzt_pkg::KIND_SAMPLE, rpzt_pkg::ZONE_NEAR_RESET);
    repeat (3) offer(rpzt_pkg::KIND_TICK, 8'hFF);
    drain();

    // Short timeout: ticks give lost reports, then repeated lost, then a sample.
    set_timeout = 16'd2;
    apply_settings();
    repeat (6) offer(rpzt_pkg::KIND_TICK, 8'h00);
    offer(rpzt_pkg::KIND_SAMPLE, rpzt_pkg::BAR_THREE_RESET);
    drain();

    // Timeout of zero: every tick reports lost.
    set_timeout = '0;
    apply_settings();
    repeat (2) offer(rpzt_pkg::KIND_TICK, 8'h55);
    offer(rpzt_pkg::KIND_SAMPLE, 8'h7F);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          set_levels = {7{8'h80}};
          set_timeout = 16'd1;
        end
        1: begin
          set_levels = {7{8'h7F}};
          set_timeout = 16'hFFFF;
        end
        2, 4: begin
          set_levels = (7 * rpzt_pkg::RSSI_W)'({$urandom, $urandom});
          set_timeout = (ph == 2) ? rpzt_pkg::TIMEOUT_W'($urandom_range(1, 8)) :
                                    rpzt_pkg::TIMEOUT_W'($urandom_range(2, 30));
        end
        3, 5: begin
          pick_ordered_levels();
          set_timeout = (ph == 3) ? rpzt_pkg::TIMEOUT_W'($urandom_range(1, 16)) :
                                    rpzt_pkg::TIMEOUT_W'($urandom_range(1, 6));
        end
        default: begin
          set_levels = {rpzt_pkg::ZONE_NEAR_RESET, rpzt_pkg::ZONE_MEDIUM_RESET,
                        rpzt_pkg::ZONE_FAR_RESET, rpzt_pkg::BAR_TEN_RESET,
                        rpzt_pkg::BAR_SEVEN_RESET, rpzt_pkg::BAR_FIVE_RESET,
                        rpzt_pkg::BAR_THREE_RESET};
          set_timeout = rpzt_pkg::TIMEOUT_W'($urandom_range(1, 10));
        end
      endcase
      apply_settings();
      if (ph == 3) long_hold_req = 1'b1;
      run_phase();
      drain();
    end

    $display("Sent %0d samples and %0d ticks under %0d register settings.",
             samples_sent, ticks_sent, settings_used);
    $display("Checked %0d reports, %0d of them lost timeouts, with %0d mismatches.",
             reports_seen, lost_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rpzt_pkg.sv
rtl/rpzt_alu.sv
rtl/rpzt_classify.sv
rtl/rssi_proximity_zone_tracker_unit.sv
verif/rpzt_report_checker.sv
verif/tb_top.sv
